// ----- design/rrss_pkg.sv -----
// Package for the round-robin sleep scheduler: shared types, codes and sizes.
// Used by rrss_ctrl, rrss_dp, round_robin_sleep_scheduler_core and the testbench.
package rrss_pkg;

    localparam int MaxTasks = 16;
    localparam int IdW      = 4;
    localparam int CntW     = 5;
    localparam int TimeW    = 32;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_YIELD  = 2'd1,
        MODE_SLEEP  = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SWITCH = 2'd1,
        EV_WOKEN = 2'd2,
        EV_DROP  = 2'd3
    } event_t;

    // Source of the task field of a result
    typedef enum logic [1:0] {
        TSEL_RUN     = 2'd0,  // running task after this step
        TSEL_IN      = 2'd1,  // task of the input item
        TSEL_SLP_RD  = 2'd2,  // front sleeper, straight from the list read
        TSEL_SLP_CAP = 2'd3   // front sleeper captured when it was woken
    } tsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RPOP,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SHIFT,
        ST_SHIFT_WAIT,
        ST_INSERT,
        ST_TICK_RD,
        ST_TICK_WAIT,
        ST_TICK_CHK,
        ST_PULL,
        ST_PULL_WAIT,
        ST_OUT
    } state_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic       load_in;     // capture input item
        logic       rd_head;     // read ready ring at head
        logic       ready_push_run;  // push running task to ring tail
        logic       ready_push_in;   // push input task to ring tail
        logic       ready_push_slp;  // push front sleeper to ring tail
        logic       pop_switch;  // running <= popped head, advance head
        logic       rd_sleep_idx; // read sleep list at index
        logic       idx_clear;   // index <= 0
        logic       idx_inc;     // index++
        logic       idx_dec;     // index--
        logic       pos_latch;   // pos <= index
        logic       idx_from_fill; // index <= fill
        logic       shift_up;    // list[index] <= read data (from index-1)
        logic       shift_down;  // list[index-1] <= read data (from index)
        logic       ins_write;   // list[pos] <= running task, wake
        logic       fill_inc;
        logic       fill_dec;
        logic       cap_sleeper; // capture front sleeper
        logic       out_load;
        event_t     out_ev;
        tsel_t      out_task_sel;
        logic       out_last;
    } rrss_cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        mode_t      mode;
        logic       ready_empty;
        logic       ready_full;
        logic       sleep_empty;
        logic       sleep_full;
        logic       idx_lt_fill;  // index < sleeper fill
        logic       idx_gt_pos;   // index > pos
        logic       rd_le_wake;   // read wake time <= computed wake
        logic       rd_le_now;    // read wake time <= now
    } rrss_stat_t;

endpackage

// ----- design/rrss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrss_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rrss_dp.sv -----
// Scheduler datapath: ready ring, sleep list memories, counters, result register.
// Depends on rrss_pkg and rrss_ram.
module rrss_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rrss_pkg::rrss_cmd_t               cmd,
    output rrss_pkg::rrss_stat_t              stat,
    input  logic [1:0]                        in_mode,
    input  logic [rrss_pkg::IdW-1:0]          in_task,
    input  logic [rrss_pkg::TimeW-1:0]        in_dur,
    input  logic [rrss_pkg::TimeW-1:0]        in_now,
    output logic [1:0]                        out_ev,
    output logic [rrss_pkg::IdW-1:0]          out_task,
    output logic                              out_last,
    output logic [rrss_pkg::CntW-1:0]         out_rcnt,
    output logic [rrss_pkg::CntW-1:0]         out_scnt
);

    localparam int IdW  = rrss_pkg::IdW;
    localparam int CntW = rrss_pkg::CntW;
    localparam int TW   = rrss_pkg::TimeW;

    logic [1:0]      mode_reg;
    logic [IdW-1:0]  task_reg;
    logic [TW-1:0]   wake_reg;
    logic [TW-1:0]   now_reg;
    logic [IdW-1:0]  head_reg, head_next;
    logic [CntW-1:0] rfill_reg, rfill_next;
    logic [CntW-1:0] sfill_reg, sfill_next;
    logic [IdW-1:0]  run_reg, run_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [CntW-1:0] pos_reg;
    logic [IdW-1:0]  slp_reg;

    logic            r_we;
    logic [IdW-1:0]  r_waddr, r_wdata, r_rdata;
    logic            s_we;
    logic [IdW-1:0]  s_waddr, s_raddr;
    logic [IdW+TW-1:0] s_wdata, s_rdata;
    logic [IdW-1:0]  s_rd_id;
    logic [CntW-1:0] tail_sum;

    // Ready ring memory
    rrss_ram #(.Width(IdW), .Depth(rrss_pkg::MaxTasks)) u_ready (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(head_reg), .rdata(r_rdata)
    );

    // Sleep list memory, {id, wake}
    rrss_ram #(.Width(IdW + TW), .Depth(rrss_pkg::MaxTasks)) u_sleep (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    assign s_rd_id = s_rdata[IdW+TW-1:TW];

    // Ring write port: tail = head + fill, taken before any pop of this cycle
    always_comb
    begin
        tail_sum = {1'b0, head_reg} + rfill_reg;
        r_waddr  = tail_sum[IdW-1:0];
        r_we     = cmd.ready_push_run | cmd.ready_push_in | cmd.ready_push_slp;
        r_wdata  = cmd.ready_push_in ? task_reg : (cmd.ready_push_slp ? s_rd_id : run_reg);
    end

    // Sleep list ports
    always_comb
    begin
        s_raddr = idx_reg[IdW-1:0];
        s_we    = cmd.shift_up | cmd.shift_down | cmd.ins_write;
        s_waddr = idx_reg[IdW-1:0];
        s_wdata = s_rdata;
        if (cmd.shift_down)
        begin
            s_waddr = idx_reg[IdW-1:0] - 1'b1;
        end
        if (cmd.ins_write)
        begin
            s_waddr = pos_reg[IdW-1:0];
            s_wdata = {run_reg, wake_reg};
        end
    end

    // Counter and pointer updates
    always_comb
    begin
        head_next  = head_reg;
        rfill_next = rfill_reg;
        sfill_next = sfill_reg;
        run_next   = run_reg;
        idx_next   = idx_reg;
        if (cmd.pop_switch)
        begin
            head_next  = head_reg + 1'b1;
            run_next   = r_rdata;
        end
        // Pop and push in the same cycle leave the fill unchanged
        if (r_we && !cmd.pop_switch)
        begin
            rfill_next = rfill_reg + 1'b1;
        end
        else if (!r_we && cmd.pop_switch)
        begin
            rfill_next = rfill_reg - 1'b1;
        end
        if (cmd.fill_inc)
        begin
            sfill_next = sfill_reg + 1'b1;
        end
        if (cmd.fill_dec)
        begin
            sfill_next = sfill_reg - 1'b1;
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.idx_from_fill)
        begin
            idx_next = sfill_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            rfill_reg <= '0;
            sfill_reg <= '0;
            run_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            rfill_reg <= rfill_next;
            sfill_reg <= sfill_next;
            run_reg   <= run_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers; a result carries the state after its own step
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= in_mode;
            task_reg <= in_task;
            wake_reg <= in_now + in_dur;
            now_reg  <= in_now;
        end
        if (cmd.pos_latch)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.cap_sleeper)
        begin
            slp_reg <= s_rd_id;
        end
        if (cmd.out_load)
        begin
            out_ev   <= cmd.out_ev;
            out_last <= cmd.out_last;
            out_rcnt <= rfill_next;
            out_scnt <= sfill_next;
            unique case (cmd.out_task_sel)
                rrss_pkg::TSEL_IN:      out_task <= task_reg;
                rrss_pkg::TSEL_SLP_RD:  out_task <= s_rd_id;
                rrss_pkg::TSEL_SLP_CAP: out_task <= slp_reg;
                rrss_pkg::TSEL_RUN:     out_task <= run_next;
            endcase
        end
    end

    // Status toward the controller
    always_comb
    begin
        stat.mode        = rrss_pkg::mode_t'(mode_reg);
        stat.ready_empty = (rfill_reg == '0);
        stat.ready_full  = (rfill_reg == CntW'(rrss_pkg::MaxTasks));
        stat.sleep_empty = (sfill_reg == '0);
        stat.sleep_full  = (sfill_reg == CntW'(rrss_pkg::MaxTasks));
        stat.idx_lt_fill = (idx_reg < sfill_reg);
        stat.idx_gt_pos  = (idx_reg > pos_reg);
        stat.rd_le_wake  = (s_rdata[TW-1:0] <= wake_reg);
        stat.rd_le_now   = (s_rdata[TW-1:0] <= now_reg);
    end

endmodule

// ----- design/rrss_ctrl.sv -----
// Scheduler controller: sequences append, yield, sleep insert and tick wake.
// Depends on rrss_pkg.
module rrss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rrss_pkg::rrss_cmd_t  cmd,
    input  rrss_pkg::rrss_stat_t stat
);

    rrss_pkg::state_t state_reg, state_next;
    rrss_pkg::state_t ret_reg, ret_next;
    logic             ovalid_reg, ovalid_next;
    logic             pend_reg, pend_next;
    logic             due;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rrss_pkg::ST_IDLE;
            ret_reg    <= rrss_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
        end
    end

    assign out_valid = ovalid_reg;

    // Front sleeper is present and its wake time has come
    assign due = !stat.sleep_empty && stat.rd_le_now;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        cmd.out_ev = rrss_pkg::EV_NONE;
        cmd.out_task_sel = rrss_pkg::TSEL_RUN;
        in_ready   = 1'b0;
        unique case (state_reg)
            rrss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = rrss_pkg::ST_DECIDE;
                end
            end
            rrss_pkg::ST_DECIDE:
            begin
                cmd.idx_clear = 1'b1;
                pend_next = 1'b0;
                unique case (stat.mode)
                    rrss_pkg::MODE_APPEND:
                    begin
                        if (stat.ready_full)
                        begin
                            cmd.out_ev = rrss_pkg::EV_DROP;
                            cmd.out_task_sel = rrss_pkg::TSEL_IN;
                        end
                        else
                        begin
                            cmd.ready_push_in = 1'b1;
                        end
                        cmd.out_last = 1'b1;
                        cmd.out_load = 1'b1;
                        ret_next = rrss_pkg::ST_IDLE;
                        state_next = rrss_pkg::ST_OUT;
                    end
                    rrss_pkg::MODE_YIELD:
                    begin
                        if (stat.ready_empty)
                        begin
                            cmd.out_last = 1'b1;
                            cmd.out_load = 1'b1;
                            ret_next = rrss_pkg::ST_IDLE;
                            state_next = rrss_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = rrss_pkg::ST_RPOP;
                        end
                    end
                    rrss_pkg::MODE_SLEEP:
                    begin
                        if (stat.ready_empty || stat.sleep_full)
                        begin
                            if (!stat.ready_empty)
                            begin
                                cmd.out_ev = rrss_pkg::EV_DROP;
                            end
                            cmd.out_last = 1'b1;
                            cmd.out_load = 1'b1;
                            ret_next = rrss_pkg::ST_IDLE;
                            state_next = rrss_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = rrss_pkg::ST_SCAN;
                        end
                    end
                    rrss_pkg::MODE_TICK:
                    begin
                        state_next = rrss_pkg::ST_TICK_RD;
                    end
                endcase
            end
            // Ring head read data is valid here; switch to it
            rrss_pkg::ST_RPOP:
            begin
                cmd.pop_switch = 1'b1;
                if (stat.mode == rrss_pkg::MODE_YIELD)
                begin
                    cmd.ready_push_run = 1'b1;
                end
                cmd.out_ev = rrss_pkg::EV_SWITCH;
                cmd.out_last = 1'b1;
                cmd.out_load = 1'b1;
                state_next = rrss_pkg::ST_OUT;
                ret_next = rrss_pkg::ST_IDLE;
            end
            // Search insert position: read entry idx
            rrss_pkg::ST_SCAN:
            begin
                if (stat.idx_lt_fill)
                begin
                    state_next = rrss_pkg::ST_SCAN_WAIT;
                end
                else
                begin
                    cmd.pos_latch = 1'b1;
                    cmd.idx_from_fill = 1'b1;
                    state_next = rrss_pkg::ST_SHIFT;
                end
            end
            rrss_pkg::ST_SCAN_WAIT:
            begin
                if (stat.rd_le_wake)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = rrss_pkg::ST_SCAN;
                end
                else
                begin
                    cmd.pos_latch = 1'b1;
                    cmd.idx_from_fill = 1'b1;
                    state_next = rrss_pkg::ST_SHIFT;
                end
            end
            // Shift entries up from the end down to pos
            rrss_pkg::ST_SHIFT:
            begin
                if (stat.idx_gt_pos)
                begin
                    cmd.idx_dec = 1'b1;
                    state_next = rrss_pkg::ST_SHIFT_WAIT;
                end
                else
                begin
                    state_next = rrss_pkg::ST_INSERT;
                end
            end
            // Entry idx-1 is being read; step idx back to the write slot
            rrss_pkg::ST_SHIFT_WAIT:
            begin
                cmd.idx_inc = 1'b1;
                state_next = rrss_pkg::ST_PULL_WAIT;
            end
            // Read data ready: move it up (sleep) or down (tick)
            rrss_pkg::ST_PULL_WAIT:
            begin
                if (stat.mode == rrss_pkg::MODE_SLEEP)
                begin
                    cmd.shift_up = 1'b1;
                    cmd.idx_dec = 1'b1;
                    state_next = rrss_pkg::ST_SHIFT;
                end
                else
                begin
                    cmd.shift_down = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next = rrss_pkg::ST_PULL;
                end
            end
            rrss_pkg::ST_INSERT:
            begin
                cmd.ins_write = 1'b1;
                cmd.fill_inc = 1'b1;
                state_next = rrss_pkg::ST_RPOP;
            end
            // Tick: point at the front entry
            rrss_pkg::ST_TICK_RD:
            begin
                cmd.idx_clear = 1'b1;
                state_next = rrss_pkg::ST_TICK_WAIT;
            end
            // Front entry is being read
            rrss_pkg::ST_TICK_WAIT:
            begin
                state_next = rrss_pkg::ST_TICK_CHK;
            end
            // Emit a held wake result once the next front is known, else act on the front
            rrss_pkg::ST_TICK_CHK:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    cmd.out_ev = rrss_pkg::EV_WOKEN;
                    cmd.out_task_sel = rrss_pkg::TSEL_SLP_CAP;
                    cmd.out_load = 1'b1;
                    if (due)
                    begin
                        ret_next = rrss_pkg::ST_TICK_CHK;
                    end
                    else
                    begin
                        cmd.out_last = 1'b1;
                        ret_next = rrss_pkg::ST_IDLE;
                    end
                    state_next = rrss_pkg::ST_OUT;
                end
                else if (!due)
                begin
                    cmd.out_last = 1'b1;
                    cmd.out_load = 1'b1;
                    ret_next = rrss_pkg::ST_IDLE;
                    state_next = rrss_pkg::ST_OUT;
                end
                else if (stat.ready_full)
                begin
                    cmd.out_ev = rrss_pkg::EV_DROP;
                    cmd.out_task_sel = rrss_pkg::TSEL_SLP_RD;
                    cmd.out_last = 1'b1;
                    cmd.out_load = 1'b1;
                    ret_next = rrss_pkg::ST_IDLE;
                    state_next = rrss_pkg::ST_OUT;
                end
                else
                begin
                    cmd.ready_push_slp = 1'b1;
                    cmd.cap_sleeper = 1'b1;
                    cmd.idx_inc = 1'b1;
                    pend_next = 1'b1;
                    state_next = rrss_pkg::ST_PULL;
                end
            end
            // Pull list down by one, entries 1..fill-1
            rrss_pkg::ST_PULL:
            begin
                if (stat.idx_lt_fill)
                begin
                    state_next = rrss_pkg::ST_PULL_WAIT;
                end
                else
                begin
                    cmd.fill_dec = 1'b1;
                    state_next = rrss_pkg::ST_TICK_RD;
                end
            end
            // Hold the result until it is taken
            rrss_pkg::ST_OUT:
            begin
                if (ovalid_reg && out_ready)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = rrss_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
        end
    end

endmodule

// ----- design/round_robin_sleep_scheduler_core.sv -----
// Top level of the round-robin sleep scheduler: stream ports, controller and datapath.
// Depends on rrss_pkg, rrss_ctrl, rrss_dp.
//
//  channel | dir | handshake             | payload
//  s_axis  | in  | s_axis_tvalid/tready  | tdata {now_ms, duration_ms, task_id, mode}
//  m_axis  | out | m_axis_tvalid/tready  | tdata, tlast
//
// Append items, and yield or sleep items that cannot act, are answered from the
// decide state; a yield switch first pops the ring head. Sleep scans the list for
// its place, moves the later entries up and inserts; tick wakes each due front
// sleeper and pulls the rest of the list down. Each sleep list read waits on the
// registered memory read. One item is worked at a time; after reset the block is
// idle at once. A stalled result holds the sequencer, and no input is taken while a result waits.
module round_robin_sleep_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] mode, [5:2] task_id, [37:6] duration_ms, [69:38] now_ms, zero pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] event_res, [5:2] task_out, [10:6] ready_count, [15:11] sleep_count
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    rrss_pkg::rrss_cmd_t  cmd;
    rrss_pkg::rrss_stat_t stat;
    logic [1:0]           ev;
    logic [3:0]           tsk;
    logic [4:0]           rcnt, scnt;

    rrss_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .stat(stat)
    );

    rrss_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_mode(s_axis_tdata[1:0]), .in_task(s_axis_tdata[5:2]),
        .in_dur(s_axis_tdata[37:6]), .in_now(s_axis_tdata[69:38]),
        .out_ev(ev), .out_task(tsk), .out_last(m_axis_tlast),
        .out_rcnt(rcnt), .out_scnt(scnt)
    );

    assign m_axis_tdata = {scnt, rcnt, tsk, ev};

    // A new item is only taken when no result is pending
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input accepted with result pending");

    // Ready and sleep counts never exceed the ring and list size
    a_rcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (rcnt <= 5'd16 && scnt <= 5'd16))
        else $error("count out of range");

endmodule

// ----- test/tb.sv -----
// Testbench for round_robin_sleep_scheduler_core: drives scheduler commands on the
// input stream and checks every result against an in-bench scheduler predictor.
// Depends on rrss_pkg and the scheduler RTL.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]     now_ms;
        logic [31:0]     duration_ms;
        logic [3:0]      task_id;
        rrss_pkg::mode_t mode;
    } cmd_t;

    typedef struct packed {
        rrss_pkg::event_t ev;
        logic [3:0]       task_out;
        logic             last;
        logic [4:0]       ready_count;
        logic [4:0]       sleep_count;
    } sched_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    round_robin_sleep_scheduler_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Predictor state: ready FIFO, sorted sleep list, running task
    logic [3:0]  run_q[$];
    logic [3:0]  slp_id[$];
    logic [31:0] slp_wake[$];
    logic [3:0]  cur_task;

    cmd_t       cmd_q[$];
    sched_res_t sched_expect_q[$];
    int         errors;
    int         n_sent;
    int         n_offered;
    int         n_results;
    int         n_woken;
    int         n_drops;
    longint     cycles;
    bit         hold_off;
    bit         stim_done;
    int         burst_left;
    int         gap_left;

    function automatic sched_res_t mk_res(rrss_pkg::event_t ev, logic [3:0] t);
        sched_res_t r;
        r.ev          = ev;
        r.task_out    = t;
        r.last        = 1'b0;
        r.ready_count = 5'(run_q.size());
        r.sleep_count = 5'(slp_id.size());
        return r;
    endfunction

    // Work out the results of one accepted command and queue them
    task automatic schedule_predict(input cmd_t c);
        sched_res_t  r[$];
        logic [31:0] wake;
        logic [3:0]  t;
        int          pos;
        case (c.mode)
            rrss_pkg::MODE_APPEND:
            begin
                if (run_q.size() >= rrss_pkg::MaxTasks)
                    r.insert(r.size(), mk_res(rrss_pkg::EV_DROP, c.task_id));
                else
                begin
                    run_q.insert(run_q.size(), c.task_id);
                    r.insert(r.size(), mk_res(rrss_pkg::EV_NONE, cur_task));
                end
            end
            rrss_pkg::MODE_YIELD:
            begin
                if (run_q.size() == 0)
                    r.insert(r.size(), mk_res(rrss_pkg::EV_NONE, cur_task));
                else
                begin
                    t = run_q[0];
                    run_q.delete(0);
                    run_q.insert(run_q.size(), cur_task);
                    cur_task = t;
                    r.insert(r.size(), mk_res(rrss_pkg::EV_SWITCH, t));
                end
            end
            rrss_pkg::MODE_SLEEP:
            begin
                if (run_q.size() == 0)
                    r.insert(r.size(), mk_res(rrss_pkg::EV_NONE, cur_task));
                else if (slp_id.size() >= rrss_pkg::MaxTasks)
                    r.insert(r.size(), mk_res(rrss_pkg::EV_DROP, cur_task));
                else
                begin
                    wake = c.now_ms + c.duration_ms;
                    pos = 0;
                    while (pos < slp_id.size() && slp_wake[pos] <= wake)
                        pos++;
                    slp_id.insert(pos, cur_task);
                    slp_wake.insert(pos, wake);
                    cur_task = run_q[0];
                    run_q.delete(0);
                    r.insert(r.size(), mk_res(rrss_pkg::EV_SWITCH, cur_task));
                end
            end
            default:
            begin
                while (slp_id.size() > 0 && slp_wake[0] <= c.now_ms)
                begin
                    t = slp_id[0];
                    if (run_q.size() >= rrss_pkg::MaxTasks)
                    begin
                        r.insert(r.size(), mk_res(rrss_pkg::EV_DROP, t));
                        break;
                    end
                    slp_id.delete(0);
                    slp_wake.delete(0);
                    run_q.insert(run_q.size(), t);
                    r.insert(r.size(), mk_res(rrss_pkg::EV_WOKEN, t));
                end
                if (r.size() == 0)
                    r.insert(r.size(), mk_res(rrss_pkg::EV_NONE, cur_task));
            end
        endcase
        r[r.size() - 1].last = 1'b1;
        foreach (r[i])
            sched_expect_q.insert(sched_expect_q.size(), r[i]);
    endtask

    function automatic cmd_t mk_cmd(rrss_pkg::mode_t m, logic [3:0] t, logic [31:0] d,
                                    logic [31:0] n);
        cmd_t c;
        c.mode        = m;
        c.task_id     = t;
        c.duration_ms = d;
        c.now_ms      = n;
        return c;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: bursts of transfers with random gaps; hold off when asked
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && n_sent < n_offered)
            ;
        else if (cmd_q.size() > 0 && !(hold_off && sched_expect_q.size() > 0))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, cmd_q[0]};
                n_offered++;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Consume the command at its accepting edge
    always @(posedge clk)
    begin
        cmd_t acc;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            acc = cmd_q[0];
            cmd_q.delete(0);
            schedule_predict(acc);
            n_sent++;
        end
    end

    // Receiver stall pattern: long runs open, then phases of random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (((cycles / 2000) % 3) == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        sched_res_t e;
        if (rst_n)
            cycles++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (sched_expect_q.size() == 0)
            begin
                $error("unexpected result transfer tdata=%h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = sched_expect_q[0];
                sched_expect_q.delete(0);
                if (e.ev == rrss_pkg::EV_WOKEN)
                    n_woken++;
                if (e.ev == rrss_pkg::EV_DROP)
                    n_drops++;
                if (m_axis_tdata[1:0] !== e.ev)
                begin
                    $error("event_res expected %0d got %0d", e.ev, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[5:2] !== e.task_out)
                begin
                    $error("task_out expected %0d got %0d", e.task_out, m_axis_tdata[5:2]);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last expected %0d got %0d", e.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[10:6] !== e.ready_count)
                begin
                    $error("ready_count expected %0d got %0d", e.ready_count,
                           m_axis_tdata[10:6]);
                    errors++;
                end
                if (m_axis_tdata[15:11] !== e.sleep_count)
                begin
                    $error("sleep_count expected %0d got %0d", e.sleep_count,
                           m_axis_tdata[15:11]);
                    errors++;
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        cmd_t        c;
        int          k;
        int          ph;
        logic [31:0] base;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cur_task      = 4'd0;
        errors        = 0;
        n_sent        = 0;
        n_offered     = 0;
        n_results     = 0;
        n_woken       = 0;
        n_drops       = 0;
        cycles        = 0;
        hold_off      = 1'b0;
        stim_done     = 1'b0;
        burst_left    = 0;
        gap_left      = 0;

        // Directed: empty queue cases, fill to overflow, wrap
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_YIELD, 4'd0, 32'd0, 32'd0));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_SLEEP, 4'd0, 32'd5, 32'd0));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF));
        for (k = 0; k < 17; k++)
            cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_APPEND, 4'(k), 32'd0, 32'd0));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_YIELD, 4'd15, '1, '1));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_SLEEP, 4'd0, 32'hFFFF_FFFF, 32'd2));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_SLEEP, 4'd0, 32'd1, 32'd0));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_SLEEP, 4'd0, 32'd1, 32'd0));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_TICK, 4'd0, 32'd0, 32'd0));
        cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Random phases: appends, yields and sleeps with ticks that wake many
        for (ph = 0; ph < 8; ph++)
        begin
            wait (cmd_q.size() == 0);
            base = (ph == 3) ? 32'hFFFF_FF00 : $urandom;
            for (k = 0; k < 50; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: c = mk_cmd(rrss_pkg::MODE_APPEND, 4'($urandom), $urandom,
                                        $urandom);
                    3, 4:    c = mk_cmd(rrss_pkg::MODE_YIELD, 4'($urandom), $urandom,
                                        $urandom);
                    5, 6, 7: c = mk_cmd(rrss_pkg::MODE_SLEEP, 4'($urandom),
                                        ($urandom_range(0, 7) == 0) ? $urandom
                                                                    : $urandom_range(0, 200),
                                        base + k);
                    default: c = mk_cmd(rrss_pkg::MODE_TICK, 4'($urandom), $urandom,
                                        ($urandom_range(0, 7) == 0) ? $urandom
                                                                    : base + k + $urandom_range(0, 150));
                endcase
                cmd_q.insert(cmd_q.size(), c);
            end
            // Drain completely once, mid run
            if (ph == 4)
            begin
                wait (cmd_q.size() == 0);
                hold_off = 1'b1;
                cmd_q.insert(cmd_q.size(), mk_cmd(rrss_pkg::MODE_TICK, 4'd0, '0, '1));
                wait (cmd_q.size() == 0 && sched_expect_q.size() == 0);
                hold_off = 1'b0;
            end
        end
        stim_done = 1'b1;
    end

    // Finish after the queues drain, or on timeout
    initial
    begin
        wait (rst_n);
        while (!(stim_done && cmd_q.size() == 0 && sched_expect_q.size() == 0
                 && !s_axis_tvalid) && cycles < 600000)
            @(posedge clk);
        if (cycles >= 600000)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            $display("Ran %0d commands giving %0d results (%0d wakes, %0d drops).",
                     n_sent, n_results, n_woken, n_drops);
            if (errors == 0 && sched_expect_q.size() == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
            $finish;
        end
    end
endmodule

// ----- round_robin_sleep_scheduler_core.f -----
design/rrss_pkg.sv
design/rrss_ram.sv
design/rrss_dp.sv
design/rrss_ctrl.sv
design/round_robin_sleep_scheduler_core.sv
test/tb.sv
